@@ rtl/nfcrx_pkg.sv @@
// ----------------------------------------------------------------------------
// nfcrx_pkg
// shared types and constants of the nfc uart response frame receiver
// ----------------------------------------------------------------------------
package nfcrx_pkg;

    // item operation codes
    typedef enum logic [1:0] {
        OP_BYTE  = 2'd0,
        OP_TICK  = 2'd1,
        OP_START = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    // status codes of the final beat
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NACK     = 3'd1,
        ST_TIMEOUT  = 3'd2,
        ST_BADFRAME = 3'd3,
        ST_BADSUM   = 3'd4,
        ST_OVERFLOW = 3'd5
    } status_t;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_RECEIVE_MODE     = 3'd0,
        CFG_EXPECTED_COMMAND = 3'd1,
        CFG_DEVICE_FRAME_ID  = 3'd2,
        CFG_PAYLOAD_CAPACITY = 3'd3,
        CFG_TIMEOUT_TICKS    = 3'd4
    } cfg_index_t;

    // frame parser phases
    typedef enum logic [14:0] {
        PH_IDLE  = 15'h0001,
        PH_SYNC  = 15'h0002,
        PH_ACK1  = 15'h0004,
        PH_ACK2  = 15'h0008,
        PH_ACK3  = 15'h0010,
        PH_LEN   = 15'h0020,
        PH_ERR1  = 15'h0040,
        PH_SKIP0 = 15'h0080,
        PH_LCS   = 15'h0100,
        PH_TFI   = 15'h0200,
        PH_CMD   = 15'h0400,
        PH_DRAIN = 15'h0800,
        PH_PARAM = 15'h1000,
        PH_DCS   = 15'h2000,
        PH_POST  = 15'h4000
    } phase_t;

    localparam logic [7:0]  SYNC_FILL        = 8'hAA;
    localparam logic [7:0]  BYTE_ZERO        = 8'h00;
    localparam logic [7:0]  BYTE_FF          = 8'hFF;
    localparam logic [7:0]  LEN_ONE          = 8'h01;
    localparam logic [7:0]  ERR_FRAME_BYTES  = 8'd4;
    localparam logic [7:0]  ZERO_LEN_SKIP    = 8'd2;
    localparam logic [7:0]  HEADER_BYTES     = 8'd2;
    localparam logic [15:0] DRAIN_SLOT_TICKS = 16'd50;
    localparam logic [15:0] TICKS_MAX        = 16'hFFFF;

    typedef struct packed {
        logic        receive_mode;
        logic [7:0]  expected_command;
        logic [7:0]  device_frame_id;
        logic [7:0]  payload_capacity;
        logic [15:0] timeout_ticks;
    } cfg_t;

    typedef struct packed {
        logic [7:0] data_byte;
        status_t    status;
        logic       last;
    } result_t;

endpackage

@@ rtl/nfc_uart_response_frame_receiver.sv @@
// ----------------------------------------------------------------------------
// nfc_uart_response_frame_receiver
// parses uart response and acknowledge frames, streams parameter bytes out
// ----------------------------------------------------------------------------
//
//  channel  | handshake                | payload
//  ---------+--------------------------+---------------------------------
//  item     | item_valid / item_stall  | op, rx_byte
//  result   | result_valid / result_stall | data_byte, status, last
//  config   | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
//  one item per cycle unless a beat meets a stalled result; an item goes from
//  the input register through the parser logic into the result register;
//  the parser state updates in the same edge that moves an item from the
//  input register onward, so back-to-back bytes and ticks never wait on it
//  rst_n clears the parser to idle and loads register defaults
//  a stalled result only holds items that produce a beat; bytes and ticks
//  that give no beat keep flowing past a full result register
//
module nfc_uart_response_frame_receiver
    import nfcrx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // item channel
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [1:0]  op,
    input  logic [7:0]  rx_byte,
    // result channel
    output logic        result_valid,
    input  logic        result_stall,
    output logic [7:0]  data_byte,
    output logic [2:0]  status,
    output logic        last,
    // config channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    cfg_t       cfg;

    // input register
    logic       in_valid_reg;
    logic [1:0] op_reg;
    logic [7:0] byte_reg;

    // result register
    logic       out_valid_reg;
    result_t    out_reg;

    logic       res_valid;
    result_t    res;
    logic       out_free;
    logic       advance;

    nfcrx_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    nfcrx_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .item_present (in_valid_reg),
        .step         (advance),
        .op           (op_reg),
        .rx_byte      (byte_reg),
        .res_valid    (res_valid),
        .res          (res)
    );

    // result slot free when empty or being taken this cycle
    assign out_free   = !out_valid_reg || !result_stall;
    // held item moves on unless it makes a beat and the slot is busy
    assign advance    = in_valid_reg && (!res_valid || out_free);
    assign item_stall = in_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (!item_stall)
            in_valid_reg <= item_valid;
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            op_reg   <= op;
            byte_reg <= rx_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= advance && res_valid;
    end

    always_ff @(posedge clk)
    begin
        if (out_free && advance && res_valid)
            out_reg <= res;
    end

    assign result_valid = out_valid_reg;
    assign data_byte    = out_reg.data_byte;
    assign status       = out_reg.status;
    assign last         = out_reg.last;

endmodule

@@ rtl/nfcrx_cfg.sv @@
// ----------------------------------------------------------------------------
// nfcrx_cfg
// configuration register file, written through the config beat channel
// ----------------------------------------------------------------------------
module nfcrx_cfg
    import nfcrx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output cfg_t        cfg
);

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.receive_mode     <= 1'b0;
            cfg_reg.expected_command <= 8'd0;
            cfg_reg.device_frame_id  <= 8'd213;
            cfg_reg.payload_capacity <= 8'd253;
            cfg_reg.timeout_ticks    <= 16'd100;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_RECEIVE_MODE:     cfg_reg.receive_mode     <= cfg_data[0];
                CFG_EXPECTED_COMMAND: cfg_reg.expected_command <= cfg_data[7:0];
                CFG_DEVICE_FRAME_ID:  cfg_reg.device_frame_id  <= cfg_data[7:0];
                CFG_PAYLOAD_CAPACITY: cfg_reg.payload_capacity <= cfg_data[7:0];
                CFG_TIMEOUT_TICKS:    cfg_reg.timeout_ticks    <= cfg_data;
                default:              ;
            endcase
        end
    end

endmodule

@@ rtl/nfcrx_core.sv @@
// ----------------------------------------------------------------------------
// nfcrx_core
// frame parser state and single-pass next-state and result logic
// ----------------------------------------------------------------------------
module nfcrx_core
    import nfcrx_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       item_present,
    input  logic       step,
    input  logic [1:0] op,
    input  logic [7:0] rx_byte,
    output logic       res_valid,
    output result_t    res
);

    phase_t      phase_reg,    phase_next;
    logic [7:0]  prev_reg,     prev_next;
    logic [7:0]  prev2_reg,    prev2_next;
    logic [7:0]  flen_reg,     flen_next;
    logic [7:0]  left_reg,     left_next;
    logic [7:0]  sum_reg,      sum_next;
    logic [15:0] ack_reg,      ack_next;
    logic [15:0] silent_reg,   silent_next;
    logic [15:0] search_reg,   search_next;

    logic [15:0] silent_inc;
    logic [15:0] search_inc;
    logic [7:0]  left_dec;
    logic [7:0]  sum_add;
    logic [7:0]  cmd_expect;
    logic [7:0]  len_minus_hdr;
    logic [7:0]  len_check;

    assign silent_inc    = (silent_reg == TICKS_MAX) ? silent_reg : silent_reg + 16'd1;
    assign search_inc    = (search_reg == TICKS_MAX) ? search_reg : search_reg + 16'd1;
    assign left_dec      = left_reg - 8'd1;
    assign sum_add       = sum_reg + rx_byte;
    assign cmd_expect    = cfg.expected_command + 8'd1;
    assign len_minus_hdr = flen_reg - HEADER_BYTES;
    assign len_check     = flen_reg + rx_byte;

    always_comb
    begin
        phase_next  = phase_reg;
        prev_next   = prev_reg;
        prev2_next  = prev2_reg;
        flen_next   = flen_reg;
        left_next   = left_reg;
        sum_next    = sum_reg;
        ack_next    = ack_reg;
        silent_next = silent_reg;
        search_next = search_reg;
        res_valid   = 1'b0;
        res         = '{data_byte: 8'd0, status: ST_OK, last: 1'b0};

        if (item_present)
        begin
            case (op)
                OP_START:
                begin
                    flen_next   = 8'd0;
                    left_next   = 8'd0;
                    sum_next    = 8'd0;
                    ack_next    = 16'd0;
                    phase_next  = PH_SYNC;
                    prev_next   = SYNC_FILL;
                    prev2_next  = SYNC_FILL;
                    search_next = 16'd0;
                    silent_next = 16'd0;
                end
                OP_TICK:
                begin
                    if (phase_reg != PH_IDLE)
                    begin
                        silent_next = silent_inc;
                        if (phase_reg == PH_DRAIN)
                        begin
                            if (silent_inc > DRAIN_SLOT_TICKS)
                            begin
                                silent_next = 16'd0;
                                left_next   = left_dec;
                                if (left_dec == 8'd0)
                                begin
                                    res_valid  = 1'b1;
                                    res.status = ST_BADFRAME;
                                    res.last   = 1'b1;
                                    phase_next = PH_IDLE;
                                end
                            end
                        end
                        else
                        begin
                            if (phase_reg == PH_SYNC)
                                search_next = search_inc;
                            if (silent_inc > cfg.timeout_ticks)
                            begin
                                res_valid  = 1'b1;
                                res.status = ST_TIMEOUT;
                                res.last   = 1'b1;
                                phase_next = PH_IDLE;
                            end
                        end
                    end
                end
                OP_BYTE:
                begin
                    if (phase_reg != PH_IDLE)
                        silent_next = 16'd0;
                    case (phase_reg)
                        PH_IDLE: ;
                        PH_SYNC:
                        begin
                            if (prev2_reg == BYTE_ZERO && prev_reg == BYTE_ZERO
                                && rx_byte == BYTE_FF)
                                phase_next = cfg.receive_mode ? PH_ACK1 : PH_LEN;
                            else
                            begin
                                prev2_next = prev_reg;
                                prev_next  = rx_byte;
                                if (search_reg > cfg.timeout_ticks)
                                begin
                                    res_valid  = 1'b1;
                                    res.status = ST_TIMEOUT;
                                    res.last   = 1'b1;
                                    phase_next = PH_IDLE;
                                end
                            end
                        end
                        PH_ACK1:
                        begin
                            ack_next   = {rx_byte, 8'd0};
                            phase_next = PH_ACK2;
                        end
                        PH_ACK2:
                        begin
                            ack_next   = {ack_reg[15:8], rx_byte};
                            phase_next = PH_ACK3;
                        end
                        PH_ACK3:
                        begin
                            res_valid  = 1'b1;
                            res.last   = 1'b1;
                            phase_next = PH_IDLE;
                            if (ack_reg[15:8] == BYTE_ZERO && ack_reg[7:0] == BYTE_FF
                                && rx_byte == BYTE_ZERO)
                                res.status = ST_OK;
                            else if (ack_reg[15:8] == BYTE_FF && ack_reg[7:0] == BYTE_ZERO
                                && rx_byte == BYTE_ZERO)
                                res.status = ST_NACK;
                            else
                                res.status = ST_BADFRAME;
                        end
                        PH_LEN:
                        begin
                            flen_next = rx_byte;
                            if (rx_byte == LEN_ONE)
                            begin
                                left_next  = ERR_FRAME_BYTES;
                                phase_next = PH_ERR1;
                            end
                            else if (rx_byte == BYTE_ZERO)
                            begin
                                left_next  = ZERO_LEN_SKIP;
                                phase_next = PH_SKIP0;
                            end
                            else
                                phase_next = PH_LCS;
                        end
                        PH_ERR1, PH_DRAIN:
                        begin
                            left_next = left_dec;
                            if (left_dec == 8'd0)
                            begin
                                res_valid  = 1'b1;
                                res.status = ST_BADFRAME;
                                res.last   = 1'b1;
                                phase_next = PH_IDLE;
                            end
                        end
                        PH_SKIP0:
                        begin
                            left_next = left_dec;
                            if (left_dec == 8'd0)
                            begin
                                phase_next  = PH_SYNC;
                                prev_next   = SYNC_FILL;
                                prev2_next  = SYNC_FILL;
                                search_next = 16'd0;
                            end
                        end
                        PH_LCS:
                        begin
                            if (len_check != 8'd0)
                            begin
                                res_valid  = 1'b1;
                                res.status = ST_BADSUM;
                                res.last   = 1'b1;
                                phase_next = PH_IDLE;
                            end
                            else if (flen_reg < HEADER_BYTES)
                            begin
                                res_valid  = 1'b1;
                                res.status = ST_BADFRAME;
                                res.last   = 1'b1;
                                phase_next = PH_IDLE;
                            end
                            else
                                phase_next = PH_TFI;
                        end
                        PH_TFI:
                        begin
                            if (rx_byte != cfg.device_frame_id)
                            begin
                                res_valid  = 1'b1;
                                res.status = ST_BADFRAME;
                                res.last   = 1'b1;
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                sum_next   = rx_byte;
                                phase_next = PH_CMD;
                            end
                        end
                        PH_CMD:
                        begin
                            if (rx_byte != cmd_expect)
                            begin
                                left_next  = flen_reg;
                                phase_next = PH_DRAIN;
                            end
                            else if (len_minus_hdr > cfg.payload_capacity)
                            begin
                                res_valid  = 1'b1;
                                res.status = ST_OVERFLOW;
                                res.last   = 1'b1;
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                sum_next   = sum_add;
                                left_next  = len_minus_hdr;
                                phase_next = (len_minus_hdr == 8'd0) ? PH_DCS : PH_PARAM;
                            end
                        end
                        PH_PARAM:
                        begin
                            sum_next      = sum_add;
                            left_next     = left_dec;
                            if (left_dec == 8'd0)
                                phase_next = PH_DCS;
                            res_valid     = 1'b1;
                            res.data_byte = rx_byte;
                        end
                        PH_DCS:
                        begin
                            sum_next   = sum_add;
                            phase_next = PH_POST;
                        end
                        PH_POST:
                        begin
                            res_valid  = 1'b1;
                            res.status = (sum_reg == 8'd0) ? ST_OK : ST_BADSUM;
                            res.last   = 1'b1;
                            phase_next = PH_IDLE;
                        end
                        default:
                            phase_next = PH_IDLE;
                    endcase
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            prev_reg   <= SYNC_FILL;
            prev2_reg  <= SYNC_FILL;
            flen_reg   <= 8'd0;
            left_reg   <= 8'd0;
            sum_reg    <= 8'd0;
            ack_reg    <= 16'd0;
            silent_reg <= 16'd0;
            search_reg <= 16'd0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            prev_reg   <= prev_next;
            prev2_reg  <= prev2_next;
            flen_reg   <= flen_next;
            left_reg   <= left_next;
            sum_reg    <= sum_next;
            ack_reg    <= ack_next;
            silent_reg <= silent_next;
            search_reg <= search_next;
        end
    end

endmodule
